// ===== src/mersenne_twister_generator_defines.svh =====
// assertion macros shared by the generator rtl
`ifndef MERSENNE_TWISTER_GENERATOR_DEFINES_SVH
`define MERSENNE_TWISTER_GENERATOR_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define MTG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mtg assertion failed: same-cycle implication");

// next-cycle implication, disabled while in reset
`define MTG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mtg assertion failed: next-cycle implication");

`endif

// ===== src/mtg_pkg.sv =====
// shared constants and types of the mt19937 generator
package mtg_pkg;

  localparam int WORD_W            = 32;
  localparam int STATE_DEPTH_DEF   = 624;
  localparam int TAP_OFFSET_DEF    = 397;

  localparam logic [WORD_W-1:0] SEED_RESET = 32'd5489;
  localparam logic [WORD_W-1:0] SEED_MULT  = 32'd1812433253;
  localparam logic [WORD_W-1:0] TWIST_XOR  = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] HIGH_BIT   = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LOW_BITS   = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] TEMPER_B   = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C   = 32'hefc6_0000;

  // shift control into the cell chain
  typedef struct packed {
    logic              shift;
    logic [WORD_W-1:0] word;
  } mtg_chain_ctl_t;

  // fixed taps of the chain
  typedef struct packed {
    logic [WORD_W-1:0] head;
    logic [WORD_W-1:0] next;
    logic [WORD_W-1:0] tap;
    logic [WORD_W-1:0] tail;
  } mtg_taps_t;

endpackage

// ===== src/mtg_if.sv =====
// request and result channel interfaces of the generator
interface mtg_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface mtg_word_if;
  logic                         valid;
  logic                         ready;
  logic [mtg_pkg::WORD_W-1:0]   random_word;

  modport source (output valid, output random_word, input ready);
  modport sink (input valid, input random_word, output ready);
endinterface

// ===== src/mtg_cell.sv =====
// one state word of the chain, loads from its neighbour on shift
module mtg_cell (
  input  logic                       clk,
  input  logic                       shift,
  input  logic [mtg_pkg::WORD_W-1:0] d,
  output logic [mtg_pkg::WORD_W-1:0] q
);

  logic [mtg_pkg::WORD_W-1:0] word_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      word_r <= d;
    end
  end

  assign q = word_r;

endmodule

// ===== src/mtg_chain.sv =====
// row of state cells forming a circular-order shift line with fixed taps
module mtg_chain #(
  parameter int STATE_DEPTH = mtg_pkg::STATE_DEPTH_DEF,
  parameter int TAP_OFFSET  = mtg_pkg::TAP_OFFSET_DEF
) (
  input  logic                    clk,
  input  mtg_pkg::mtg_chain_ctl_t ctl,
  output mtg_pkg::mtg_taps_t      taps
);

  logic [mtg_pkg::WORD_W-1:0] cell_q [STATE_DEPTH];

  for (genvar i = 0; i < STATE_DEPTH; i++) begin : g_cell
    logic [mtg_pkg::WORD_W-1:0] cell_d;
    if (i == STATE_DEPTH - 1) begin : g_tail
      assign cell_d = ctl.word;
    end else begin : g_body
      assign cell_d = cell_q[i+1];
    end
    mtg_cell u_cell (
      .clk   (clk),
      .shift (ctl.shift),
      .d     (cell_d),
      .q     (cell_q[i])
    );
  end

  assign taps.head = cell_q[0];
  assign taps.next = cell_q[1];
  assign taps.tap  = cell_q[TAP_OFFSET];
  assign taps.tail = cell_q[STATE_DEPTH-1];

endmodule

// ===== src/mtg_twist.sv =====
// per-word twist of the head taps and output tempering
module mtg_twist (
  input  mtg_pkg::mtg_taps_t         taps,
  output logic [mtg_pkg::WORD_W-1:0] new_word,
  output logic [mtg_pkg::WORD_W-1:0] tempered
);

  logic [mtg_pkg::WORD_W-1:0] y;
  logic [mtg_pkg::WORD_W-1:0] t1;
  logic [mtg_pkg::WORD_W-1:0] t2;
  logic [mtg_pkg::WORD_W-1:0] t3;

  always_comb begin
    y        = (taps.head & mtg_pkg::HIGH_BIT) | (taps.next & mtg_pkg::LOW_BITS);
    new_word = taps.tap ^ (y >> 1) ^ (y[0] ? mtg_pkg::TWIST_XOR : '0);
    t1       = new_word ^ (new_word >> 11);
    t2       = t1 ^ ((t1 << 7) & mtg_pkg::TEMPER_B);
    t3       = t2 ^ ((t2 << 15) & mtg_pkg::TEMPER_C);
    tempered = t3 ^ (t3 >> 18);
  end

endmodule

// ===== src/mersenne_twister_generator.sv =====
// top level of the mt19937 pseudo-random word generator
// MT19937 generator: every request on in_req returns one tempered 32-bit word on
// out_word. The 624-word state lives in a row of word cells that shift by one
// place per generated word; the new word is built from three fixed taps (head,
// head+1, head+397) and enters at the tail, which is the standard twist done
// one word at a time. A plain request's word is registered in the cycle after
// acceptance; back-to-back requests stream at one word per clock while out_word
// drains the result register. The first request after reset, and any request
// with restart set, first reseeds the chain from the seed register: the seed
// recurrence feeds one word per cycle through a single 32x32 multiplier into
// the tail, and once all 624 words are seeded a generate step yields its word.
// A seed write is only stored; it takes effect at the next seeding.
// Seed writes are expected only while the generator is idle.
`include "mersenne_twister_generator_defines.svh"

module mersenne_twister_generator #(
  parameter int STATE_DEPTH = mtg_pkg::STATE_DEPTH_DEF,
  parameter int TAP_OFFSET  = mtg_pkg::TAP_OFFSET_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  mtg_req_if.sink                    in_req,
  mtg_word_if.source                 out_word,
  input  logic                       cfg_wr_en,
  input  logic [mtg_pkg::WORD_W-1:0] cfg_wr_data
);

  localparam int IDX_W = $clog2(STATE_DEPTH);

  // control states
  localparam logic [1:0] ST_RUN  = 2'd0;  // taking requests
  localparam logic [1:0] ST_SEED = 2'd1;  // filling the chain from the seed
  localparam logic [1:0] ST_GEN  = 2'd2;  // first word after a reseed

  logic [1:0]                 state_r;
  logic [1:0]                 state_nxt;
  logic [IDX_W-1:0]           seed_cnt_r;
  logic [IDX_W-1:0]           seed_cnt_nxt;
  logic                       seeded_r;
  logic                       seeded_nxt;
  logic [mtg_pkg::WORD_W-1:0] seed_r;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic [mtg_pkg::WORD_W-1:0] out_data_r;

  logic                       out_free;
  logic                       req_accept;
  logic                       need_seed;
  logic                       gen_fire;
  logic                       seed_step;
  logic                       seed_last;
  logic [mtg_pkg::WORD_W-1:0] seed_mix;
  logic [mtg_pkg::WORD_W-1:0] seed_prod;
  logic [mtg_pkg::WORD_W-1:0] seed_word;
  logic [mtg_pkg::WORD_W-1:0] twist_word;
  logic [mtg_pkg::WORD_W-1:0] tempered_word;

  mtg_pkg::mtg_chain_ctl_t    chain_ctl;
  mtg_pkg::mtg_taps_t         chain_taps;

  // seed register, stored only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= mtg_pkg::SEED_RESET;
    end else if (cfg_wr_en) begin
      seed_r <= cfg_wr_data;
    end
  end

  // handshake: the output register frees as it is drained
  assign out_free     = !out_valid_r || out_word.ready;
  assign in_req.ready = (state_r == ST_RUN) && out_free;
  assign req_accept   = in_req.valid && in_req.ready;
  assign need_seed    = in_req.restart || !seeded_r;

  // a word is generated on a plain request or once seeding is done
  assign gen_fire  = (req_accept && !need_seed) || ((state_r == ST_GEN) && out_free);
  assign seed_step = (state_r == ST_SEED);
  assign seed_last = seed_cnt_r == IDX_W'(STATE_DEPTH - 1);

  // seed recurrence from the word last pushed into the tail
  assign seed_mix  = chain_taps.tail ^ (chain_taps.tail >> 30);
  assign seed_prod = mtg_pkg::SEED_MULT * seed_mix;
  assign seed_word = (seed_cnt_r == '0) ? seed_r
                                        : seed_prod + mtg_pkg::WORD_W'(seed_cnt_r);

  assign chain_ctl.shift = gen_fire || seed_step;
  assign chain_ctl.word  = seed_step ? seed_word : twist_word;

  mtg_chain #(
    .STATE_DEPTH (STATE_DEPTH),
    .TAP_OFFSET  (TAP_OFFSET)
  ) u_chain (
    .clk  (clk),
    .ctl  (chain_ctl),
    .taps (chain_taps)
  );

  mtg_twist u_twist (
    .taps     (chain_taps),
    .new_word (twist_word),
    .tempered (tempered_word)
  );

  // sequencing
  always_comb begin
    state_nxt    = state_r;
    seed_cnt_nxt = seed_cnt_r;
    seeded_nxt   = seeded_r;
    case (state_r)
      ST_RUN: begin
        if (req_accept && need_seed) begin
          state_nxt    = ST_SEED;
          seed_cnt_nxt = '0;
        end
      end
      ST_SEED: begin
        seed_cnt_nxt = seed_cnt_r + 1'b1;
        if (seed_last) begin
          state_nxt  = ST_GEN;
          seeded_nxt = 1'b1;
        end
      end
      ST_GEN: begin
        if (out_free) begin
          state_nxt = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (gen_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_word.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      seed_cnt_r  <= '0;
      seeded_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seed_cnt_r  <= seed_cnt_nxt;
      seeded_r    <= seeded_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result register, payload only
  always_ff @(posedge clk) begin
    if (gen_fire) begin
      out_data_r <= tempered_word;
    end
  end

  assign out_word.valid       = out_valid_r;
  assign out_word.random_word = out_data_r;

  // no request is taken while the chain is being seeded
  `MTG_ASSERT_IMPL(a_no_req_in_seed, clk, rst_n, state_r != ST_RUN, !in_req.ready)
  // a request that needs seeding starts the seeding pass
  `MTG_ASSERT_NEXT(a_seed_start, clk, rst_n, req_accept && need_seed, state_r == ST_SEED)
  // the last seeding step hands over to the first generate
  `MTG_ASSERT_NEXT(a_seed_done, clk, rst_n, seed_step && seed_last, state_r == ST_GEN && seeded_r)
  // every generated word lands in the result register
  `MTG_ASSERT_NEXT(a_gen_loads, clk, rst_n, gen_fire, out_valid_r)

endmodule
